/* hw/rtl/gammatone_biquad_cascade_macros.svh */
`ifndef GAMMATONE_BIQUAD_CASCADE_MACROS_SVH
`define GAMMATONE_BIQUAD_CASCADE_MACROS_SVH

// Check that a condition holds in the same cycle as a trigger.
`define GBC_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define GBC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

// Check that a condition holds on every cycle out of reset.
`define GBC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

/* hw/rtl/gbc_pkg.sv */
`timescale 1ns / 1ps

package gbc_pkg;

    // Default cascade length and number of distinct per-section a1 values
    localparam int SECTIONS_DEF = 4;
    localparam int NUM_A1       = 4;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 48;
    localparam int COEF_W   = 40;
    localparam int GAIN_W   = 32;
    localparam int WIDE_W   = 90;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FEED_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ONE0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ONE1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ONE2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ONE3 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_ONE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_TWO  = 3'd7;

    // Filter modes
    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [WIDE_W-1:0] t_wide;

    // One sample travelling down the cascade
    typedef struct packed {
        logic  mode;
        logic  block_start;
        t_data data;
    } t_sample;

    // Coefficients shared by every section
    typedef struct packed {
        t_coef              feed_gain;
        logic [GAIN_W-1:0]  inverse_gain;
        t_coef              back_one;
        t_coef              back_two;
    } t_coefs;

    localparam t_wide MAX48_W = t_wide'(48'sh7FFF_FFFF_FFFF);
    localparam t_wide MIN48_W = -MAX48_W - t_wide'(1);

    // Clamp a wide signed value into 48 bits
    function automatic t_data sat48(input t_wide v);
        t_data r;
        if (v > MAX48_W) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < MIN48_W) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/gbc_in_if.sv */
`timescale 1ns / 1ps

interface gbc_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic                 block_start;
    logic signed [15:0]   sample_in;

    modport source (output valid, output mode, output block_start, output sample_in,
                    input ready);
    modport sink   (input valid, input mode, input block_start, input sample_in,
                    output ready);
endinterface

/* hw/rtl/gbc_out_if.sv */
`timescale 1ns / 1ps

interface gbc_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [47:0]   sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* hw/rtl/gammatone_biquad_cascade.sv */
`timescale 1ns / 1ps
`include "gammatone_biquad_cascade_macros.svh"

// Channel   Dir   Payload                           Request taken when
// i_in      in    mode, block_start, sample_in      valid && ready
// o_out     out   sample_out (Q31.16, saturated)    valid && ready
// i_cfg_*   in    index 0..7, 40-bit data           i_cfg_we
//
// Each section cell runs 11 steps on its shared 25x41 multiplier, then hands
// its result to the next cell. Synchronous active-low reset clears
// coefficients, section state and control. A stalled output keeps up to two
// results; input ready drops while a request is in the cascade or both result
// slots are full.
module gammatone_biquad_cascade #(
    parameter int SECTIONS = gbc_pkg::SECTIONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    gbc_in_if.sink                             i_in,
    gbc_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    gbc_pkg::t_coef               r_feed_gain;
    logic [gbc_pkg::GAIN_W-1:0]   r_inverse_gain;
    gbc_pkg::t_coef               r_feed_one [gbc_pkg::NUM_A1];
    gbc_pkg::t_coef               r_back_one;
    gbc_pkg::t_coef               r_back_two;
    logic                         r_busy;

    gbc_pkg::t_coefs              w_coefs;
    logic [SECTIONS:0]            w_vld;
    gbc_pkg::t_sample             w_smp [SECTIONS+1];
    logic [SECTIONS-1:0]          w_busy;
    logic                         w_accept;
    logic                         w_hold_full;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_gain    <= '0;
            r_inverse_gain <= '0;
            r_back_one     <= '0;
            r_back_two     <= '0;
            for (int i = 0; i < gbc_pkg::NUM_A1; i++) begin
                r_feed_one[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbc_pkg::CFG_FEED_GAIN: r_feed_gain    <= $signed(i_cfg_data);
                gbc_pkg::CFG_INV_GAIN:  r_inverse_gain <= i_cfg_data[gbc_pkg::GAIN_W-1:0];
                gbc_pkg::CFG_FEED_ONE0: r_feed_one[0]  <= $signed(i_cfg_data);
                gbc_pkg::CFG_FEED_ONE1: r_feed_one[1]  <= $signed(i_cfg_data);
                gbc_pkg::CFG_FEED_ONE2: r_feed_one[2]  <= $signed(i_cfg_data);
                gbc_pkg::CFG_FEED_ONE3: r_feed_one[3]  <= $signed(i_cfg_data);
                gbc_pkg::CFG_BACK_ONE:  r_back_one     <= $signed(i_cfg_data);
                gbc_pkg::CFG_BACK_TWO:  r_back_two     <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign w_coefs.feed_gain    = r_feed_gain;
    assign w_coefs.inverse_gain = r_inverse_gain;
    assign w_coefs.back_one     = r_back_one;
    assign w_coefs.back_two     = r_back_two;

    // Take a request only when the cascade is empty and a result slot is free
    assign i_in.ready = !r_busy && !w_hold_full;
    assign w_accept   = i_in.valid && i_in.ready;

    // Feed the first cell; sample is widened to Q31.16
    assign w_vld[0]              = w_accept;
    assign w_smp[0].mode         = i_in.mode;
    assign w_smp[0].block_start  = i_in.block_start;
    assign w_smp[0].data         = {{(gbc_pkg::DATA_W - 2*gbc_pkg::SAMPLE_W){i_in.sample_in[15]}},
                                    i_in.sample_in, {gbc_pkg::SAMPLE_W{1'b0}}};

    // Chain of section cells
    for (genvar k = 0; k < SECTIONS; k++) begin : g_sec
        localparam int A1_IDX = k % gbc_pkg::NUM_A1;
        gbc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_vld[k]),
            .i_smp      (w_smp[k]),
            .i_coefs    (w_coefs),
            .i_feed_one (r_feed_one[A1_IDX]),
            .o_valid    (w_vld[k+1]),
            .o_smp      (w_smp[k+1]),
            .o_busy     (w_busy[k])
        );
    end

    // Track the request in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_vld[SECTIONS]) begin
            r_busy <= 1'b0;
        end
    end

    gbc_result_buf u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_vld[SECTIONS]),
        .i_data      (w_smp[SECTIONS].data),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_data      (o_out.sample_out),
        .o_hold_full (w_hold_full)
    );

    `GBC_ASSERT_NOW(a_push_room, w_vld[SECTIONS], !w_hold_full, "result with no free slot")
    `GBC_ASSERT_NOW(a_push_owned, w_vld[SECTIONS], r_busy, "result with no request in flight")
    `GBC_ASSERT_ALWAYS(a_one_cell, $onehot0(w_busy), "more than one section cell active")
    `GBC_ASSERT_NEXT(a_start_cell, w_accept, w_busy[0], "first cell did not start")

endmodule

/* hw/rtl/gbc_cell.sv */
`timescale 1ns / 1ps

// One biquad section: holds its own delay state and runs four
// multiplications through a single 25x41 multiplier, low half then high half.
module gbc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gbc_pkg::t_sample  i_smp,
    input  gbc_pkg::t_coefs   i_coefs,
    input  gbc_pkg::t_coef    i_feed_one,
    output logic              o_valid,
    output gbc_pkg::t_sample  o_smp,
    output logic              o_busy
);

    // Sequencer steps
    localparam logic [3:0] ST_A_LO  = 4'd0;
    localparam logic [3:0] ST_A_HI  = 4'd1;
    localparam logic [3:0] ST_B_LO  = 4'd2;
    localparam logic [3:0] ST_B_HI  = 4'd3;
    localparam logic [3:0] ST_C_LO  = 4'd4;
    localparam logic [3:0] ST_C_HI  = 4'd5;
    localparam logic [3:0] ST_C_GET = 4'd6;
    localparam logic [3:0] ST_T_SET = 4'd7;
    localparam logic [3:0] ST_D_LO  = 4'd8;
    localparam logic [3:0] ST_D_HI  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    // Product slots
    localparam logic [1:0] PROD_A = 2'd0;
    localparam logic [1:0] PROD_B = 2'd1;
    localparam logic [1:0] PROD_C = 2'd2;
    localparam logic [1:0] PROD_D = 2'd3;

    localparam int MUL_A_W = 25;
    localparam int MUL_C_W = 41;
    localparam int PROD_W  = MUL_A_W + MUL_C_W;
    localparam int MC_W    = 56;

    logic                       r_act;
    logic [3:0]                 r_step;
    gbc_pkg::t_sample           r_smp;
    logic signed [PROD_W-1:0]   r_plo;
    logic signed [PROD_W-1:0]   r_phi;
    logic signed [MC_W-1:0]     r_ma;
    logic signed [MC_W-1:0]     r_mb;
    logic signed [MC_W-1:0]     r_mc;
    gbc_pkg::t_data             r_t;
    gbc_pkg::t_data             r_d1;
    gbc_pkg::t_data             r_d2;
    gbc_pkg::t_data             r_x1;
    gbc_pkg::t_data             r_x2;
    gbc_pkg::t_data             r_y1;
    logic                       r_out_valid;
    gbc_pkg::t_sample           r_out_smp;

    logic                       w_clr;
    logic                       w_inv;
    gbc_pkg::t_data             e_d1;
    gbc_pkg::t_data             e_d2;
    gbc_pkg::t_data             e_x1;
    gbc_pkg::t_data             e_x2;
    gbc_pkg::t_data             e_y1;
    logic [1:0]                 w_sel;
    logic                       w_mul_en;
    gbc_pkg::t_data             w_op;
    logic signed [MUL_C_W-1:0]  w_coef;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [PROD_W-1:0]   w_prod;
    gbc_pkg::t_wide             w_full;
    logic signed [MC_W-1:0]     w_m_now;
    gbc_pkg::t_data             w_y_fwd;
    gbc_pkg::t_data             w_v_inv;
    gbc_pkg::t_data             w_y_inv;
    gbc_pkg::t_data             w_d1_new;
    gbc_pkg::t_data             w_d2_new;

    // Block start reads all state as zero
    assign w_clr = r_smp.block_start;
    assign w_inv = (r_smp.mode == gbc_pkg::MODE_INV);
    assign e_d1  = w_clr ? '0 : r_d1;
    assign e_d2  = w_clr ? '0 : r_d2;
    assign e_x1  = w_clr ? '0 : r_x1;
    assign e_x2  = w_clr ? '0 : r_x2;
    assign e_y1  = w_clr ? '0 : r_y1;

    // Map step to product slot; high half on odd steps
    assign w_sel    = r_step[3] ? PROD_D : r_step[2:1];
    assign w_mul_en = r_act && ((r_step <= ST_C_HI) || (r_step == ST_D_LO)
                                || (r_step == ST_D_HI));

    // Pick operand and coefficient for the current product
    always_comb begin
        unique case (w_sel)
            PROD_A: begin
                w_op   = w_inv ? e_x1 : r_smp.data;
                w_coef = w_inv ? MUL_C_W'(i_coefs.back_one) : MUL_C_W'(i_coefs.feed_gain);
            end
            PROD_B: begin
                w_op   = w_inv ? e_x2 : r_smp.data;
                w_coef = w_inv ? MUL_C_W'(i_coefs.back_two) : MUL_C_W'(i_feed_one);
            end
            PROD_C: begin
                w_op   = w_inv ? e_y1 : r_t;
                w_coef = w_inv ? MUL_C_W'(i_feed_one) : MUL_C_W'(i_coefs.back_one);
            end
            default: begin
                w_op   = r_t;
                w_coef = w_inv ? $signed({9'd0, i_coefs.inverse_gain})
                               : MUL_C_W'(i_coefs.back_two);
            end
        endcase
    end

    assign w_mul_a = r_step[0] ? $signed({w_op[47], w_op[47:24]})
                               : $signed({1'b0, w_op[23:0]});
    assign w_prod  = w_mul_a * w_coef;

    // Recombine halves: full = hi * 2^24 + lo
    assign w_full  = $signed({r_phi, 24'd0}) + $signed({{24{r_plo[PROD_W-1]}}, r_plo});
    assign w_m_now = $signed(w_full[87:32]);

    assign w_y_fwd  = gbc_pkg::sat48(gbc_pkg::t_wide'(r_ma) + gbc_pkg::t_wide'(e_d1));
    assign w_v_inv  = gbc_pkg::sat48(gbc_pkg::t_wide'(r_smp.data) + gbc_pkg::t_wide'(r_ma)
                                     + gbc_pkg::t_wide'(r_mb) - gbc_pkg::t_wide'(r_mc));
    assign w_y_inv  = gbc_pkg::sat48(gbc_pkg::t_wide'($signed(w_full[89:8])));
    assign w_d1_new = gbc_pkg::sat48(gbc_pkg::t_wide'(r_mb) - gbc_pkg::t_wide'(r_mc)
                                     + gbc_pkg::t_wide'(e_d2));
    assign w_d2_new = gbc_pkg::sat48(-gbc_pkg::t_wide'(w_m_now));

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !r_act) begin
            r_smp <= i_smp;
        end
        if (w_mul_en) begin
            if (r_step[0]) begin
                r_phi <= w_prod;
            end else begin
                r_plo <= w_prod;
            end
        end
        if (r_act) begin
            if (r_step == ST_B_LO) begin
                r_ma <= w_m_now;
            end
            if (r_step == ST_C_LO) begin
                r_mb <= w_m_now;
            end
            if (r_step == ST_C_GET) begin
                r_mc <= w_m_now;
            end
            if ((r_step == ST_B_HI) && !w_inv) begin
                r_t <= w_y_fwd;
            end
            if ((r_step == ST_T_SET) && w_inv) begin
                r_t <= w_v_inv;
            end
        end
        if (r_act && (r_step == ST_DONE)) begin
            r_out_smp.mode        <= r_smp.mode;
            r_out_smp.block_start <= r_smp.block_start;
            r_out_smp.data        <= w_inv ? w_y_inv : r_t;
        end
    end

    // Sequencer and section state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_step      <= ST_A_LO;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
        end else begin
            r_out_valid <= 1'b0;
            if (!r_act) begin
                if (i_valid) begin
                    r_act  <= 1'b1;
                    r_step <= ST_A_LO;
                end
            end else if (r_step == ST_DONE) begin
                r_act       <= 1'b0;
                r_out_valid <= 1'b1;
                if (w_inv) begin
                    r_x2 <= e_x1;
                    r_x1 <= r_smp.data;
                    r_y1 <= w_y_inv;
                    r_d1 <= e_d1;
                    r_d2 <= e_d2;
                end else begin
                    r_d1 <= w_d1_new;
                    r_d2 <= w_d2_new;
                    r_x1 <= e_x1;
                    r_x2 <= e_x2;
                    r_y1 <= e_y1;
                end
            end else begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_smp   = r_out_smp;
    assign o_busy  = r_act;

endmodule

/* hw/rtl/gbc_result_buf.sv */
`timescale 1ns / 1ps

// Two-slot result buffer: output register plus one hold slot.
module gbc_result_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gbc_pkg::t_data  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output gbc_pkg::t_data  o_data,
    output logic            o_hold_full
);

    logic            r_ov;
    logic            r_hv;
    gbc_pkg::t_data  r_od;
    gbc_pkg::t_data  r_hd;
    logic            w_pop;

    assign w_pop = r_ov && i_ready;

    // Refill the output slot from hold first, then from a new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else if (!r_ov || w_pop) begin
            if (r_hv) begin
                r_ov <= 1'b1;
                r_hv <= i_push;
            end else begin
                r_ov <= i_push;
            end
        end else if (i_push) begin
            r_hv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_pop) begin
            if (r_hv) begin
                r_od <= r_hd;
                if (i_push) begin
                    r_hd <= i_data;
                end
            end else if (i_push) begin
                r_od <= i_data;
            end
        end else if (i_push) begin
            r_hd <= i_data;
        end
    end

    assign o_valid     = r_ov;
    assign o_data      = r_od;
    assign o_hold_full = r_hv;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import gbc_pkg::*;

    localparam int N_SECT   = SECTIONS_DEF;
    localparam int HOLD_AT  = 120;
    localparam int HOLD_LEN = 700;

    localparam longint TOP48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint BOT48 = -TOP48 - 64'sd1;

    // Stable resonator: a0 = 0.05, 1/a0 = 20, b1 = -1.8, b2 = 0.9
    localparam longint TUNED_GAIN = 64'sd214748365;
    localparam longint TUNED_INV  = 64'sd5120;
    localparam longint TUNED_B1   = -64'sd7730941133;
    localparam longint TUNED_B2   = 64'sd3865470566;
    localparam longint TUNED_A1 [4] = '{64'sd128849019, -64'sd85899346,
                                        64'sd42949673, 64'sd171798692};

    typedef enum {MIX_TUNED, MIX_JITTER, MIX_RANDOM, MIX_MAX, MIX_MIN} coef_mix_e;

    typedef struct {
        logic               mode;
        logic               block_start;
        logic signed [15:0] sample;
        bit                 drain;
    } sample_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gbc_in_if  in_if ();
    gbc_out_if out_if ();

    gammatone_biquad_cascade dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow coefficients and section state
    t_coef       cfg_gain = '0;
    logic [31:0] cfg_inv_gain = '0;
    t_coef       cfg_feed_one [4] = '{default: '0};
    t_coef       cfg_back_one = '0;
    t_coef       cfg_back_two = '0;

    t_data fwd_d1 [N_SECT] = '{default: '0};
    t_data fwd_d2 [N_SECT] = '{default: '0};
    t_data inv_x1 [N_SECT] = '{default: '0};
    t_data inv_x2 [N_SECT] = '{default: '0};
    t_data inv_y1 [N_SECT] = '{default: '0};

    sample_req_t pending_samples [$];
    t_data       expected_out [$];

    int fail_count = 0;
    int taken_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    int in_gap_left = 0;
    int in_calm_left = 0;
    bit in_calm = 1'b0;
    int out_gap_left = 0;
    int out_calm_left = 0;
    bit out_calm = 1'b0;
    sample_req_t next_req;
    t_data want;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Q31.16 times Q7.32, floored back to Q31.16
    function automatic longint mul_q32(input t_data x, input t_coef c);
        logic signed [95:0] xw;
        logic signed [95:0] cw;
        logic signed [95:0] pw;
        xw = x;
        cw = c;
        pw = (xw * cw) >>> 32;
        return pw[63:0];
    endfunction

    function automatic t_data clamp48(input longint v);
        if (v > TOP48) return TOP48[47:0];
        if (v < BOT48) return BOT48[47:0];
        return v[47:0];
    endfunction

    // Multiply by the unsigned Q24.8 reciprocal, floor and clamp
    function automatic t_data scale_by_gain(input t_data v, input logic [31:0] g);
        logic signed [95:0] xw;
        logic signed [95:0] gw;
        logic signed [95:0] pw;
        xw = v;
        gw = {64'd0, g};
        pw = (xw * gw) >>> 8;
        if (pw > TOP48) return TOP48[47:0];
        if (pw < BOT48) return BOT48[47:0];
        return pw[47:0];
    endfunction

    // Run one sample through the cascade and update the section state
    function automatic t_data filter_sample(input logic mode, input logic start,
                                            input logic signed [15:0] smp);
        t_data cur;
        t_data y;
        t_data v;
        t_coef a1;
        cur = smp;
        cur = cur <<< 16;
        if (start) begin
            for (int k = 0; k < N_SECT; k++) begin
                fwd_d1[k] = '0;
                fwd_d2[k] = '0;
                inv_x1[k] = '0;
                inv_x2[k] = '0;
                inv_y1[k] = '0;
            end
        end
        for (int s = 0; s < N_SECT; s++) begin
            a1 = cfg_feed_one[s % NUM_A1];
            if (mode == MODE_FWD) begin
                y = clamp48(mul_q32(cur, cfg_gain) + fwd_d1[s]);
                fwd_d1[s] = clamp48(mul_q32(cur, a1) - mul_q32(y, cfg_back_one) + fwd_d2[s]);
                fwd_d2[s] = clamp48(-mul_q32(y, cfg_back_two));
            end else begin
                v = clamp48(longint'(cur) + mul_q32(inv_x1[s], cfg_back_one)
                            + mul_q32(inv_x2[s], cfg_back_two) - mul_q32(inv_y1[s], a1));
                y = scale_by_gain(v, cfg_inv_gain);
                inv_x2[s] = inv_x1[s];
                inv_x1[s] = cur;
                inv_y1[s] = y;
            end
            cur = y;
        end
        return cur;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] draw_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = int'($urandom_range(0, 1023)) - 512;
            7:          v = 32767;
            8:          v = -32768;
            default:    v = 0;
        endcase
        return v[15:0];
    endfunction

    // Sender: offer queued requests, predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.mode        <= MODE_FWD;
            in_if.block_start <= 1'b0;
            in_if.sample_in   <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_out.push_back(filter_sample(in_if.mode, in_if.block_start,
                                                     in_if.sample_in));
                taken_count <= taken_count + 1;
                in_gap_left = in_calm ? 0 : pick_gap();
            end
            if (in_calm_left == 0) begin
                in_calm_left = $urandom_range(100, 600);
                in_calm = ($urandom_range(0, 2) == 0);
            end else begin
                in_calm_left--;
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (in_gap_left != 0) begin
                    in_gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_samples.size() != 0 &&
                             !(pending_samples[0].drain && expected_out.size() != 0)) begin
                    next_req = pending_samples.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.mode        <= next_req.mode;
                    in_if.block_start <= next_req.block_start;
                    in_if.sample_in   <= next_req.sample;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Hold the receiver off once for a long stretch so the cascade backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && taken_count >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Receiver: check each result against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_out.size() == 0) begin
                    $error("sample_out: no result pending, got %0d", out_if.sample_out);
                    fail_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (out_if.sample_out !== want) begin
                        $error("sample_out: expected %0d, got %0d", want, out_if.sample_out);
                        fail_count++;
                    end
                end
            end
            if (out_calm_left == 0) begin
                out_calm_left = $urandom_range(100, 600);
                out_calm = ($urandom_range(0, 2) == 0);
            end else begin
                out_calm_left--;
            end
            if (out_gap_left != 0) begin
                out_gap_left--;
                out_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!out_calm) out_gap_left = pick_gap();
            end
        end
    end

    task automatic queue_sample(input logic mode, input logic start,
                                input logic signed [15:0] smp, input bit drain);
        sample_req_t r;
        r.mode = mode;
        r.block_start = start;
        r.sample = smp;
        r.drain = drain;
        pending_samples.push_back(r);
    endtask

    // Wait until every request has come back out, checked once the edge has settled
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || expected_out.size() != 0 || in_if.valid);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= word;
        case (idx)
            CFG_FEED_GAIN: cfg_gain = word;
            CFG_INV_GAIN:  cfg_inv_gain = word[31:0];
            CFG_FEED_ONE0: cfg_feed_one[0] = word;
            CFG_FEED_ONE1: cfg_feed_one[1] = word;
            CFG_FEED_ONE2: cfg_feed_one[2] = word;
            CFG_FEED_ONE3: cfg_feed_one[3] = word;
            CFG_BACK_ONE:  cfg_back_one = word;
            CFG_BACK_TWO:  cfg_back_two = word;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Load a full coefficient set of the given flavor
    task automatic program_filter(input coef_mix_e mix);
        longint gain, inv, b1, b2;
        longint a1 [4];
        case (mix)
            MIX_TUNED: begin
                gain = TUNED_GAIN;
                inv  = TUNED_INV;
                b1   = TUNED_B1;
                b2   = TUNED_B2;
                foreach (a1[k]) a1[k] = TUNED_A1[k];
            end
            MIX_JITTER: begin
                gain = $urandom_range(0, 32'h4000_0000);
                inv  = $urandom_range(256, 65535);
                b2   = 64'sd2147483648 + $urandom_range(0, 32'h7800_0000);
                b1   = -(64'sd4294967296 + $urandom_range(0, 32'hC000_0000));
                foreach (a1[k]) a1[k] = longint'(int'($urandom) >>> 2);
            end
            MIX_RANDOM: begin
                gain = {$urandom, $urandom};
                inv  = {$urandom, $urandom};
                b1   = {$urandom, $urandom};
                b2   = {$urandom, $urandom};
                foreach (a1[k]) a1[k] = {$urandom, $urandom};
            end
            MIX_MAX: begin
                gain = 64'h7F_FFFF_FFFF;
                inv  = 64'hFF_FFFF_FFFF;
                b1   = 64'h7F_FFFF_FFFF;
                b2   = 64'h7F_FFFF_FFFF;
                foreach (a1[k]) a1[k] = 64'h7F_FFFF_FFFF;
            end
            default: begin
                gain = 64'h80_0000_0000;
                inv  = 0;
                b1   = 64'h80_0000_0000;
                b2   = 64'h80_0000_0000;
                foreach (a1[k]) a1[k] = 64'h80_0000_0000;
            end
        endcase
        write_reg(CFG_FEED_GAIN, 40'(gain));
        write_reg(CFG_INV_GAIN,  40'(inv));
        write_reg(CFG_FEED_ONE0, 40'(a1[0]));
        write_reg(CFG_FEED_ONE1, 40'(a1[1]));
        write_reg(CFG_FEED_ONE2, 40'(a1[2]));
        write_reg(CFG_FEED_ONE3, 40'(a1[3]));
        write_reg(CFG_BACK_ONE,  40'(b1));
        write_reg(CFG_BACK_TWO,  40'(b2));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly whole blocks opened by block_start, the rest loose requests
    task automatic add_bursts(input int count);
        int n;
        int len;
        logic m;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(3, 40);
                m = $urandom_range(0, 1);
                for (int k = 0; k < len; k++)
                    queue_sample(m, k == 0, draw_sample(), $urandom_range(0, 99) == 0);
            end else begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    queue_sample($urandom_range(0, 1), $urandom_range(0, 3) == 0,
                                 draw_sample(), 1'b0);
            end
            n += len;
        end
    endtask

    task automatic run_phase(input coef_mix_e mix, input int count);
        wait_drained();
        program_filter(mix);
        add_bursts(count);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Coefficients at their reset value: everything filters to zero
        queue_sample(MODE_FWD, 1'b0, 16'sd12345, 1'b0);
        queue_sample(MODE_INV, 1'b0, -16'sd32768, 1'b0);
        queue_sample(MODE_INV, 1'b1, 16'sd32767, 1'b0);
        wait_drained();

        // Directed: extremes, mode switches that keep the other state, clears
        program_filter(MIX_TUNED);
        queue_sample(MODE_FWD, 1'b1, 16'sd32767, 1'b0);
        queue_sample(MODE_FWD, 1'b0, 16'sd0, 1'b0);
        queue_sample(MODE_FWD, 1'b0, 16'sd0, 1'b0);
        queue_sample(MODE_FWD, 1'b0, -16'sd32768, 1'b0);
        queue_sample(MODE_FWD, 1'b0, -16'sd1, 1'b0);
        queue_sample(MODE_FWD, 1'b0, 16'sd1, 1'b0);
        queue_sample(MODE_INV, 1'b0, 16'sd32767, 1'b0);
        queue_sample(MODE_INV, 1'b0, -16'sd32768, 1'b0);
        queue_sample(MODE_INV, 1'b0, 16'sd0, 1'b0);
        queue_sample(MODE_FWD, 1'b0, 16'sd100, 1'b0);
        queue_sample(MODE_INV, 1'b0, 16'sd0, 1'b0);
        queue_sample(MODE_INV, 1'b1, -16'sd1, 1'b1);
        queue_sample(MODE_FWD, 1'b0, 16'sd0, 1'b0);
        queue_sample(MODE_FWD, 1'b1, -16'sd32768, 1'b0);
        queue_sample(MODE_INV, 1'b1, 16'sd32767, 1'b0);
        queue_sample(MODE_INV, 1'b0, 16'sd32767, 1'b0);

        run_phase(MIX_TUNED, 250);
        run_phase(MIX_MAX, 120);
        run_phase(MIX_JITTER, 300);
        run_phase(MIX_RANDOM, 200);
        run_phase(MIX_MIN, 120);
        run_phase(MIX_JITTER, 300);
        run_phase(MIX_TUNED, 250);
        run_phase(MIX_RANDOM, 150);
        run_phase(MIX_JITTER, 150);

        // Let the cascade settle, then catch any stray result
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Give up on a hung handshake
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* gammatone_biquad_cascade.f */
+incdir+hw/rtl
hw/rtl/gbc_pkg.sv
hw/rtl/gbc_in_if.sv
hw/rtl/gbc_out_if.sv
hw/rtl/gbc_cell.sv
hw/rtl/gbc_result_buf.sv
hw/rtl/gammatone_biquad_cascade.sv
sim/tb.sv
